FILE: rtl/core/dxi_pkg.sv
// dxi_pkg: widths, constants, status codes and shared types for the
// directional index block; no dependencies, used by every file in rtl/core
package dxi_pkg;

   localparam int PRICE_W    = 32;
   localparam int MOVE_W     = PRICE_W + 1;
   localparam int SUM_W      = 48;
   localparam int TOT_W      = SUM_W + 1;
   localparam int REM_W      = TOT_W + 4;
   localparam int ALU_W      = REM_W + 1;
   localparam int COUNT_W    = 17;
   localparam int INDEX_W    = 14;
   localparam int STATUS_W   = 2;
   localparam int DIGIT_W    = 3;

   localparam int REQ_DATA_W = 3 * PRICE_W;
   localparam int RSP_DATA_W = 16;

   localparam int MAX_BARS   = 65536;

   localparam logic [COUNT_W-1:0] PERIOD_RESET = COUNT_W'(14);
   localparam logic [COUNT_W-1:0] COUNT_MAX    = COUNT_W'(MAX_BARS);
   localparam logic [SUM_W-1:0]   SUM_MAX      = '1;

   // decimal digits after the leading one of 10000 * diff / tot
   localparam logic [DIGIT_W-1:0] FRAC_DIGITS  = DIGIT_W'(4);

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FEW_BARS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_RANGE = 2'd2;

   typedef struct packed {
      logic neg;
      logic zero;
   } alu_flags_type;

endpackage

FILE: rtl/core/dxi_alu.sv
// dxi_alu: shared two's complement add / subtract unit with sign and zero flags
// depends on dxi_pkg
module dxi_alu (
   input  logic [dxi_pkg::ALU_W-1:0] alu_a,
   input  logic [dxi_pkg::ALU_W-1:0] alu_b,
   input  logic                      alu_sub,
   output logic [dxi_pkg::ALU_W-1:0] alu_result,
   output dxi_pkg::alu_flags_type    alu_flags
);

   always_comb begin
      if (alu_sub) begin
         alu_result = alu_a - alu_b;
      end else begin
         alu_result = alu_a + alu_b;
      end
      alu_flags.neg  = alu_result[dxi_pkg::ALU_W-1];
      alu_flags.zero = (alu_result == '0);
   end

endmodule

FILE: rtl/core/directional_index_over_bars.sv
// directional_index_over_bars: top level, bar sequencer around one shared adder
// depends on dxi_pkg and dxi_alu
//
// Takes one price bar per beat and keeps saturating 48-bit sums of plus
// movement, minus movement and true range over a series; the beat with tlast
// ends the series and yields one result beat: the index 10000*|P-M|/(P+M),
// truncated, with a status in tuser (ok, too few bars, zero true range).
// All arithmetic runs through a single 54-bit add/subtract unit stepped by a
// state machine, so req_tready is high only between bars. The first bar of a
// series goes straight to the post step, every later bar runs the movement,
// compare, true range and sum steps first (two absolute values take an extra
// step when negative). A last bar with too few bars or no true range goes
// from the post step to the result, one with P+M of zero after the total, and
// one that reaches the division runs a decimal long division, one trial
// subtraction per cycle, up to ten per digit over the four digits after the
// leading one. A last bar also waits while the previous result is still held.
// The result waits in an output register, so the next series may start before
// it is taken. The period register is written through csr_write / csr_wdata.
module directional_index_over_bars (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [dxi_pkg::COUNT_W-1:0]       csr_wdata,   // period_bars
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dxi_pkg::REQ_DATA_W-1:0]    req_tdata,   // bar_high, bar_low, bar_close
   input  logic                              req_tlast,   // last_bar
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dxi_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // index_value, zero fill
   output logic [dxi_pkg::STATUS_W-1:0]      rsp_tuser    // status
);

   localparam int PW = dxi_pkg::PRICE_W;
   localparam int MW = dxi_pkg::MOVE_W;
   localparam int AW = dxi_pkg::ALU_W;
   localparam int SW = dxi_pkg::SUM_W;
   localparam int TW = dxi_pkg::TOT_W;
   localparam int RW = dxi_pkg::REM_W;
   localparam int CW = dxi_pkg::COUNT_W;
   localparam int IW = dxi_pkg::INDEX_W;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_UP   = 5'd1;
   localparam logic [4:0] S_DOWN = 5'd2;
   localparam logic [4:0] S_CMP  = 5'd3;
   localparam logic [4:0] S_T1   = 5'd4;
   localparam logic [4:0] S_T2A  = 5'd5;
   localparam logic [4:0] S_T2B  = 5'd6;
   localparam logic [4:0] S_TMX2 = 5'd7;
   localparam logic [4:0] S_T3A  = 5'd8;
   localparam logic [4:0] S_T3B  = 5'd9;
   localparam logic [4:0] S_TMX3 = 5'd10;
   localparam logic [4:0] S_ADDP = 5'd11;
   localparam logic [4:0] S_ADDM = 5'd12;
   localparam logic [4:0] S_ADDR = 5'd13;
   localparam logic [4:0] S_POST = 5'd14;
   localparam logic [4:0] S_TOT  = 5'd15;
   localparam logic [4:0] S_DIFA = 5'd16;
   localparam logic [4:0] S_DIFB = 5'd17;
   localparam logic [4:0] S_DSUB = 5'd18;
   localparam logic [4:0] S_DMUL = 5'd19;
   localparam logic [4:0] S_EMIT = 5'd20;

   // control and series state
   logic [4:0]                    state_ff, state_in;
   logic [CW-1:0]                 period_ff, period_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [PW-1:0]                 prev_hi_ff, prev_hi_in;
   logic [PW-1:0]                 prev_lo_ff, prev_lo_in;
   logic [PW-1:0]                 prev_cl_ff, prev_cl_in;
   logic [SW-1:0]                 plus_ff, plus_in;
   logic [SW-1:0]                 minus_ff, minus_in;
   logic [SW-1:0]                 range_ff, range_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [PW-1:0]                 hi_ff, hi_in;
   logic [PW-1:0]                 lo_ff, lo_in;
   logic [PW-1:0]                 cl_ff, cl_in;
   logic                          last_ff, last_in;
   logic [MW-1:0]                 up_ff, up_in;
   logic [MW-1:0]                 down_ff, down_in;
   logic                          add_plus_ff, add_plus_in;
   logic                          add_minus_ff, add_minus_in;
   logic [MW-1:0]                 tr_ff, tr_in;
   logic [PW-1:0]                 cand_ff, cand_in;
   logic [TW-1:0]                 tot_ff, tot_in;
   logic [RW-1:0]                 rem_ff, rem_in;
   logic [IW-1:0]                 quo_ff, quo_in;
   logic [dxi_pkg::DIGIT_W-1:0]   digit_ff, digit_in;
   logic [dxi_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [IW-1:0]                 rsp_index_ff, rsp_index_in;
   logic [dxi_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic [AW-1:0]                 alu_a;
   logic [AW-1:0]                 alu_b;
   logic                          alu_sub;
   logic [AW-1:0]                 alu_result;
   dxi_pkg::alu_flags_type        alu_flags;

   logic [CW-1:0]                 count_inc;
   logic                          req_beat;

   dxi_alu u_alu (
      .alu_a      (alu_a),
      .alu_b      (alu_b),
      .alu_sub    (alu_sub),
      .alu_result (alu_result),
      .alu_flags  (alu_flags)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = dxi_pkg::RSP_DATA_W'(rsp_index_ff);
   assign rsp_tuser  = rsp_status_ff;

   assign count_inc = (count_ff < dxi_pkg::COUNT_MAX) ? count_ff + CW'(1) : count_ff;

   // operand select for the shared adder
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         S_UP: begin
            alu_a   = AW'(hi_ff);
            alu_b   = AW'(prev_hi_ff);
            alu_sub = 1'b1;
         end
         S_DOWN: begin
            alu_a   = AW'(prev_lo_ff);
            alu_b   = AW'(lo_ff);
            alu_sub = 1'b1;
         end
         S_CMP: begin
            alu_a   = {{(AW-MW){up_ff[MW-1]}}, up_ff};
            alu_b   = {{(AW-MW){down_ff[MW-1]}}, down_ff};
            alu_sub = 1'b1;
         end
         S_T1: begin
            alu_a   = AW'(hi_ff);
            alu_b   = AW'(lo_ff);
            alu_sub = 1'b1;
         end
         S_T2A: begin
            alu_a   = AW'(hi_ff);
            alu_b   = AW'(prev_cl_ff);
            alu_sub = 1'b1;
         end
         S_T2B: begin
            alu_a   = AW'(prev_cl_ff);
            alu_b   = AW'(hi_ff);
            alu_sub = 1'b1;
         end
         S_T3A: begin
            alu_a   = AW'(lo_ff);
            alu_b   = AW'(prev_cl_ff);
            alu_sub = 1'b1;
         end
         S_T3B: begin
            alu_a   = AW'(prev_cl_ff);
            alu_b   = AW'(lo_ff);
            alu_sub = 1'b1;
         end
         S_TMX2, S_TMX3: begin
            alu_a   = AW'(cand_ff);
            alu_b   = {{(AW-MW){tr_ff[MW-1]}}, tr_ff};
            alu_sub = 1'b1;
         end
         S_ADDP: begin
            alu_a = AW'(plus_ff);
            alu_b = add_plus_ff ? AW'(up_ff) : '0;
         end
         S_ADDM: begin
            alu_a = AW'(minus_ff);
            alu_b = add_minus_ff ? AW'(down_ff) : '0;
         end
         S_ADDR: begin
            alu_a = AW'(range_ff);
            alu_b = AW'(tr_ff);
         end
         S_TOT: begin
            alu_a = AW'(plus_ff);
            alu_b = AW'(minus_ff);
         end
         S_DIFA: begin
            alu_a   = AW'(plus_ff);
            alu_b   = AW'(minus_ff);
            alu_sub = 1'b1;
         end
         S_DIFB: begin
            alu_a   = AW'(minus_ff);
            alu_b   = AW'(plus_ff);
            alu_sub = 1'b1;
         end
         S_DSUB: begin
            alu_a   = AW'(rem_ff);
            alu_b   = AW'(tot_ff);
            alu_sub = 1'b1;
         end
         S_DMUL: begin
            // rem * 10 as rem * 8 + rem * 2
            alu_a = AW'({rem_ff, 3'b000});
            alu_b = AW'({rem_ff, 1'b0});
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      period_in     = period_ff;
      count_in      = count_ff;
      prev_hi_in    = prev_hi_ff;
      prev_lo_in    = prev_lo_ff;
      prev_cl_in    = prev_cl_ff;
      plus_in       = plus_ff;
      minus_in      = minus_ff;
      range_in      = range_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      cl_in         = cl_ff;
      last_in       = last_ff;
      up_in         = up_ff;
      down_in       = down_ff;
      add_plus_in   = add_plus_ff;
      add_minus_in  = add_minus_ff;
      tr_in         = tr_ff;
      cand_in       = cand_ff;
      tot_in        = tot_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      digit_in      = digit_ff;
      status_in     = status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_write) begin
         period_in = csr_wdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               hi_in   = req_tdata[PW-1:0];
               lo_in   = req_tdata[2*PW-1:PW];
               cl_in   = req_tdata[3*PW-1:2*PW];
               last_in = req_tlast;
               state_in = (count_ff != '0) ? S_UP : S_POST;
            end
         end
         S_UP: begin
            up_in    = alu_result[MW-1:0];
            state_in = S_DOWN;
         end
         S_DOWN: begin
            down_in  = alu_result[MW-1:0];
            state_in = S_CMP;
         end
         S_CMP: begin
            add_plus_in  = !alu_flags.neg && !alu_flags.zero &&
                           !up_ff[MW-1] && (up_ff != '0);
            add_minus_in = alu_flags.neg && !down_ff[MW-1] && (down_ff != '0);
            state_in     = S_T1;
         end
         S_T1: begin
            tr_in    = alu_result[MW-1:0];
            state_in = S_T2A;
         end
         S_T2A: begin
            cand_in  = alu_result[PW-1:0];
            state_in = alu_flags.neg ? S_T2B : S_TMX2;
         end
         S_T2B: begin
            cand_in  = alu_result[PW-1:0];
            state_in = S_TMX2;
         end
         S_TMX2: begin
            if (!alu_flags.neg) begin
               tr_in = MW'(cand_ff);
            end
            state_in = S_T3A;
         end
         S_T3A: begin
            cand_in  = alu_result[PW-1:0];
            state_in = alu_flags.neg ? S_T3B : S_TMX3;
         end
         S_T3B: begin
            cand_in  = alu_result[PW-1:0];
            state_in = S_TMX3;
         end
         S_TMX3: begin
            if (!alu_flags.neg) begin
               tr_in = MW'(cand_ff);
            end
            state_in = S_ADDP;
         end
         S_ADDP: begin
            plus_in  = alu_result[SW] ? dxi_pkg::SUM_MAX : alu_result[SW-1:0];
            state_in = S_ADDM;
         end
         S_ADDM: begin
            minus_in = alu_result[SW] ? dxi_pkg::SUM_MAX : alu_result[SW-1:0];
            state_in = S_ADDR;
         end
         S_ADDR: begin
            range_in = alu_result[SW] ? dxi_pkg::SUM_MAX : alu_result[SW-1:0];
            state_in = S_POST;
         end
         S_POST: begin
            count_in   = count_inc;
            prev_hi_in = hi_ff;
            prev_lo_in = lo_ff;
            prev_cl_in = cl_ff;
            quo_in     = '0;
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (count_inc < period_ff) begin
               status_in = dxi_pkg::STATUS_FEW_BARS;
               state_in  = S_EMIT;
            end else if (range_ff == '0) begin
               status_in = dxi_pkg::STATUS_NO_RANGE;
               state_in  = S_EMIT;
            end else begin
               status_in = dxi_pkg::STATUS_OK;
               state_in  = S_TOT;
            end
         end
         S_TOT: begin
            tot_in   = alu_result[TW-1:0];
            digit_in = dxi_pkg::FRAC_DIGITS;
            state_in = alu_flags.zero ? S_EMIT : S_DIFA;
         end
         S_DIFA: begin
            rem_in   = alu_result[RW-1:0];
            state_in = alu_flags.neg ? S_DIFB : S_DSUB;
         end
         S_DIFB: begin
            rem_in   = alu_result[RW-1:0];
            state_in = S_DSUB;
         end
         S_DSUB: begin
            if (!alu_flags.neg) begin
               rem_in = alu_result[RW-1:0];
               quo_in = quo_ff + IW'(1);
            end else if (digit_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_DMUL;
            end
         end
         S_DMUL: begin
            rem_in   = alu_result[RW-1:0];
            quo_in   = IW'({quo_ff, 3'b000}) + IW'({quo_ff, 1'b0});
            digit_in = digit_ff - 1'b1;
            state_in = S_DSUB;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = quo_ff;
               rsp_status_in = status_ff;
               count_in      = '0;
               prev_hi_in    = '0;
               prev_lo_in    = '0;
               prev_cl_in    = '0;
               plus_in       = '0;
               minus_in      = '0;
               range_in      = '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         period_ff    <= dxi_pkg::PERIOD_RESET;
         count_ff     <= '0;
         prev_hi_ff   <= '0;
         prev_lo_ff   <= '0;
         prev_cl_ff   <= '0;
         plus_ff      <= '0;
         minus_ff     <= '0;
         range_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         count_ff     <= count_in;
         prev_hi_ff   <= prev_hi_in;
         prev_lo_ff   <= prev_lo_in;
         prev_cl_ff   <= prev_cl_in;
         plus_ff      <= plus_in;
         minus_ff     <= minus_in;
         range_ff     <= range_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff         <= hi_in;
      lo_ff         <= lo_in;
      cl_ff         <= cl_in;
      last_ff       <= last_in;
      up_ff         <= up_in;
      down_ff       <= down_in;
      add_plus_ff   <= add_plus_in;
      add_minus_ff  <= add_minus_in;
      tr_ff         <= tr_in;
      cand_ff       <= cand_in;
      tot_ff        <= tot_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      digit_ff      <= digit_in;
      status_ff     <= status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for directional_index_over_bars, random bar series
// with idle and stall phases across several period settings, every index beat
// checked against a scoreboard model; depends on dxi_pkg and the block's rtl only
module tb_top;

   typedef struct {
      logic [dxi_pkg::INDEX_W-1:0]  value;
      logic [dxi_pkg::STATUS_W-1:0] status;
   } dx_result_type;

   class dx_index_board;
      logic [dxi_pkg::COUNT_W-1:0] period;
      logic [dxi_pkg::PRICE_W-1:0] prev_high, prev_low, prev_close;
      logic [dxi_pkg::COUNT_W-1:0] bar_count;
      logic [dxi_pkg::SUM_W-1:0]   plus_sum, minus_sum, range_sum;
      dx_result_type               index_queue[$];
      int                          errors;

      function new();
         period = dxi_pkg::PERIOD_RESET;
         errors = 0;
         clear_series();
      endfunction

      function void clear_series();
         prev_high  = '0;
         prev_low   = '0;
         prev_close = '0;
         bar_count  = '0;
         plus_sum   = '0;
         minus_sum  = '0;
         range_sum  = '0;
      endfunction

      function int pending();
         return index_queue.size();
      endfunction

      function logic [dxi_pkg::SUM_W-1:0] sat_add(logic [dxi_pkg::SUM_W-1:0] acc,
                                                  logic [dxi_pkg::MOVE_W:0] v);
         logic [dxi_pkg::SUM_W:0] s;
         s = {1'b0, acc} + v;
         return s[dxi_pkg::SUM_W] ? dxi_pkg::SUM_MAX : s[dxi_pkg::SUM_W-1:0];
      endfunction

      function logic [dxi_pkg::MOVE_W:0] magnitude(logic signed [dxi_pkg::MOVE_W:0] v);
         return (v < 0) ? -v : v;
      endfunction

      function void take_bar(logic [dxi_pkg::PRICE_W-1:0] hi, logic [dxi_pkg::PRICE_W-1:0] lo,
                             logic [dxi_pkg::PRICE_W-1:0] cl, logic last);
         logic signed [dxi_pkg::MOVE_W:0] up, down, tr, t2, t3;
         logic [dxi_pkg::TOT_W-1:0]       total;
         logic [dxi_pkg::SUM_W-1:0]       diff;
         logic [63:0]                     scaled;
         dx_result_type                   r;
         if (bar_count != 0) begin
            up   = $signed({2'b00, hi}) - $signed({2'b00, prev_high});
            down = $signed({2'b00, prev_low}) - $signed({2'b00, lo});
            tr   = $signed({2'b00, hi}) - $signed({2'b00, lo});
            t2   = magnitude($signed({2'b00, hi}) - $signed({2'b00, prev_close}));
            t3   = magnitude($signed({2'b00, lo}) - $signed({2'b00, prev_close}));
            if (t2 > tr) tr = t2;
            if (t3 > tr) tr = t3;
            if (up > down && up > 0) plus_sum = sat_add(plus_sum, up);
            if (down > up && down > 0) minus_sum = sat_add(minus_sum, down);
            range_sum = sat_add(range_sum, tr);
         end
         if (bar_count < dxi_pkg::COUNT_MAX) bar_count = bar_count + 1'b1;
         prev_high  = hi;
         prev_low   = lo;
         prev_close = cl;
         if (last) begin
            r.value  = '0;
            r.status = dxi_pkg::STATUS_OK;
            if (bar_count < period) begin
               r.status = dxi_pkg::STATUS_FEW_BARS;
            end else if (range_sum == 0) begin
               r.status = dxi_pkg::STATUS_NO_RANGE;
            end else begin
               total = {1'b0, plus_sum} + minus_sum;
               if (total != 0) begin
                  diff    = (plus_sum > minus_sum) ? plus_sum - minus_sum
                                                   : minus_sum - plus_sum;
                  scaled  = diff * 64'd10000;
                  scaled  = scaled / total;
                  r.value = scaled[dxi_pkg::INDEX_W-1:0];
               end
            end
            index_queue.insert(index_queue.size(), r);
            clear_series();
         end
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task take_index(logic [dxi_pkg::INDEX_W-1:0] value, logic [dxi_pkg::STATUS_W-1:0] status);
         dx_result_type r;
         if (index_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected beat, index %0d status %0d", value, status));
            return;
         end
         r = index_queue.pop_front();
         if (value !== r.value)
            report_mismatch($sformatf("index %0d, expected %0d", value, r.value));
         if (status !== r.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, r.status));
      endtask
   endclass

   localparam int STALL_LIMIT = 4000;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           csr_write  = 1'b0;
   logic [dxi_pkg::COUNT_W-1:0]    csr_wdata  = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [dxi_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           req_tlast  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [dxi_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [dxi_pkg::STATUS_W-1:0]   rsp_tuser;

   dx_index_board board;
   int unsigned   send_idle_pct  = 0;
   int unsigned   recv_stall_pct = 0;
   int unsigned   bars_sent      = 0;
   int unsigned   idle_cycles    = 0;

   int          phase_period [9] = '{1, 0, 5, 65536, 131071, -1, -1, 14, -2};
   int unsigned phase_send   [9] = '{0, 79, 0, 31, 0, 79, 0, 31, 0};
   int unsigned phase_stall  [9] = '{0, 0, 79, 31, 0, 0, 79, 31, 0};
   int unsigned phase_bars   [9] = '{250, 250, 250, 100, 100, 250, 250, 250, 250};

   directional_index_over_bars DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.take_index(rsp_tdata[dxi_pkg::INDEX_W-1:0], rsp_tuser);
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("FAIL directional_index_over_bars");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_bar(logic [dxi_pkg::PRICE_W-1:0] hi, logic [dxi_pkg::PRICE_W-1:0] lo,
                           logic [dxi_pkg::PRICE_W-1:0] cl, logic last);
      // sender may idle at random before presenting each bar
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {cl, lo, hi};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.take_bar(hi, lo, cl, last);
      bars_sent++;
   endtask

   // drop valid and wait for every outstanding index beat
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic write_period(logic [dxi_pkg::COUNT_W-1:0] value);
      settle();
      repeat (64) @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      board.period = value;
   endtask

   function automatic logic [dxi_pkg::PRICE_W-1:0] pick_extreme();
      case ($urandom_range(0, 2))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_series(int unsigned period_now);
      int unsigned                 hint, len, mode, spread;
      logic [dxi_pkg::PRICE_W-1:0] base, hi, lo, cl, swap;
      hint = (period_now == 0) ? 4 : ((period_now > 20) ? 20 : period_now);
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 3);
      else len = $urandom_range((hint > 2) ? hint - 2 : 1, hint + 4);
      mode   = $urandom_range(0, 99);
      spread = 1 << $urandom_range(0, 24);
      base   = $urandom();
      for (int i = 0; i < len; i++) begin
         if (mode < 70) begin
            // random walk with occasional inverted bars
            base = base + $urandom_range(0, 2 * spread) - spread;
            hi   = base + $urandom_range(0, spread);
            lo   = base - $urandom_range(0, spread);
            cl   = base + $urandom_range(0, spread) - spread / 2;
            if ($urandom_range(0, 9) == 0) begin
               swap = hi;
               hi   = lo;
               lo   = swap;
            end
         end else if (mode < 82) begin
            hi = $urandom();
            lo = $urandom();
            cl = $urandom();
         end else if (mode < 90) begin
            hi = base;
            lo = base;
            cl = base;
         end else begin
            hi = pick_extreme();
            lo = pick_extreme();
            cl = pick_extreme();
         end
         send_bar(hi, lo, cl, i == len - 1);
      end
   endtask

   task automatic run_phase(int unsigned period_now, int unsigned send_pct,
                            int unsigned stall_pct, int unsigned count);
      int unsigned target;
      write_period(period_now[dxi_pkg::COUNT_W-1:0]);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      target = bars_sent + count;
      while (bars_sent < target) begin
         if ($urandom_range(0, 59) == 0) settle();
         send_series(period_now);
      end
   endtask

   initial begin
      int unsigned period_now;
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_bar(7, 3, 5, 1'b1);
      write_period(2);
      send_bar(0, 0, 0, 1'b0);
      send_bar('1, '1, '1, 1'b1);
      send_bar('1, '1, '1, 1'b0);
      send_bar(0, 0, 0, 1'b1);
      send_bar(5, 5, 5, 1'b0);
      send_bar(5, 5, 5, 1'b1);
      send_bar(100, 200, 150, 1'b0);
      send_bar(90, 300, 50, 1'b1);
      send_bar(100, 50, 75, 1'b0);
      send_bar(110, 40, 75, 1'b1);
      send_bar(1000, 900, 950, 1'b0);
      send_bar(1100, 950, 1000, 1'b0);
      send_bar(1050, 800, 900, 1'b1);
      send_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
      send_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
      send_bar(42, 40, 41, 1'b1);

      for (int p = 0; p < 9; p++) begin
         if (phase_period[p] == -1) period_now = $urandom_range(2, 16);
         else if (phase_period[p] == -2) period_now = $urandom_range(1, 20);
         else period_now = phase_period[p];
         run_phase(period_now, phase_send[p], phase_stall[p], phase_bars[p]);
      end

      settle();
      repeat (64) @(posedge clock);
      if (board.pending() != 0)
         board.report_mismatch($sformatf("%0d index beats never arrived", board.pending()));
      if (board.errors == 0) begin
         $display("PASS directional_index_over_bars");
      end else begin
         $display("FAIL directional_index_over_bars");
      end
      $finish;
   end

endmodule
